// File: sv/bsis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsis_pkg
// Shared constants, register codes and controller/datapath bundles for the
// binomial series inverse square root unit.
// ----------------------------------------------------------------------------
package bsis_pkg;

  localparam int FRACTION_BITS_DEF = 30;

  localparam int X_W     = 31;
  localparam int SUM_W   = 46;
  localparam int K_W     = 16;
  localparam int TOL_W   = 27;
  localparam int LIMIT_W = 16;

  localparam int Q_IN     = 30;
  localparam int TOL_FRAC = 30;
  localparam int CMP_FRAC = 40;
  localparam int CMP_W    = CMP_FRAC + 1;

  localparam int APB_DW      = 32;
  localparam int PADDR_W     = 3;
  localparam int REG_SEL_BIT = 2;

  localparam logic [TOL_W-1:0]   TOL_RST   = 27'd1073742;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd50000;

  localparam logic REG_TOLERANCE  = 1'b0;
  localparam logic REG_TERM_LIMIT = 1'b1;

  typedef struct packed {
    logic load_x;
    logic mul1_start;
    logic mul2_start;
    logic div_start;
    logic mul_step;
    logic div_step;
    logic acc_term;
    logic fin;
    logic load_out;
  } bsis_cmd_t;

  typedef struct packed {
    logic stop;
    logic last;
  } bsis_sts_t;

endpackage

// File: sv/bsis_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsis_regs
// APB-style configuration registers: tolerance and term limit.
// ----------------------------------------------------------------------------
module bsis_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsis_pkg::PADDR_W-1:0]  paddr,
  input  logic [bsis_pkg::APB_DW-1:0]   pwdata,
  output logic [bsis_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [bsis_pkg::TOL_W-1:0]    tolerance,
  output logic [bsis_pkg::LIMIT_W-1:0]  term_limit
);
  import bsis_pkg::*;

  logic [TOL_W-1:0]   tolerance_r;
  logic [LIMIT_W-1:0] term_limit_r;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[REG_SEL_BIT];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r  <= TOL_RST;
      term_limit_r <= LIMIT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_TOLERANCE:  tolerance_r  <= pwdata[TOL_W-1:0];
        REG_TERM_LIMIT: term_limit_r <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TOLERANCE:  prdata = APB_DW'(tolerance_r);
      REG_TERM_LIMIT: prdata = APB_DW'(term_limit_r);
      default:        prdata = '0;
    endcase
  end

  assign tolerance  = tolerance_r;
  assign term_limit = term_limit_r;

endmodule

// File: sv/bsis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsis_ctrl
// Sequencer for one series evaluation: load, test, two shift-add multiplies,
// restoring divide, accumulate, and result transfer.
// ----------------------------------------------------------------------------
module bsis_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  bsis_pkg::bsis_sts_t  sts,
  output bsis_pkg::bsis_cmd_t  cmd
);
  import bsis_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TEST = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_LD2  = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_LDD  = 4'd5;
  localparam logic [3:0] S_DV   = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_x = 1'b1;
          state_nxt  = S_TEST;
        end
      end
      S_TEST: begin
        if (sts.stop) begin
          cmd.fin   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.mul1_start = 1'b1;
          state_nxt      = S_M1;
        end
      end
      S_M1: begin
        cmd.mul_step = 1'b1;
        if (sts.last) state_nxt = S_LD2;
      end
      S_LD2: begin
        cmd.mul2_start = 1'b1;
        state_nxt      = S_M2;
      end
      S_M2: begin
        cmd.mul_step = 1'b1;
        if (sts.last) state_nxt = S_LDD;
      end
      S_LDD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DV;
      end
      S_DV: begin
        cmd.div_step = 1'b1;
        if (sts.last) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc_term = 1'b1;
        state_nxt    = S_TEST;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: sv/bsis_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsis_dp
// Term and sum registers, shared shift-add multiplier, restoring divider,
// stop test and output rescaling.
// ----------------------------------------------------------------------------
module bsis_dp #(
  parameter int FRACTION_BITS = bsis_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  bsis_pkg::bsis_cmd_t                 cmd,
  output bsis_pkg::bsis_sts_t                 sts,
  input  logic signed [bsis_pkg::X_W-1:0]     in_x_value,
  input  logic [bsis_pkg::TOL_W-1:0]          tolerance,
  input  logic [bsis_pkg::LIMIT_W-1:0]        term_limit,
  output logic signed [bsis_pkg::SUM_W-1:0]   out_series_sum,
  output logic [bsis_pkg::K_W-1:0]            out_terms_used,
  output logic                                out_limit_hit
);
  import bsis_pkg::*;

  localparam int TW       = FRACTION_BITS;
  localparam int SW       = TW + K_W;
  localparam int XM_W     = X_W;
  localparam int A_W      = TW + XM_W;
  localparam int K2_W     = K_W + 1;
  localparam int DV_W     = TW + K2_W;
  localparam int CNT_W    = $clog2(DV_W);
  localparam int UP       = (FRACTION_BITS >= Q_IN) ? FRACTION_BITS - Q_IN : 0;
  localparam int DN       = (FRACTION_BITS >= Q_IN) ? 1 : Q_IN + 1 - FRACTION_BITS;
  localparam int DN_SH    = (FRACTION_BITS < Q_IN) ? Q_IN - FRACTION_BITS : 0;
  localparam int TO_CMP   = CMP_FRAC - FRACTION_BITS;
  localparam int TOL_SH   = CMP_FRAC - TOL_FRAC;
  localparam int SCW      = SW + DN_SH;
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(XM_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DV_W - 1);

  logic                  xneg_r;
  logic [XM_W-1:0]       xm_r;
  logic [TW-1:0]         tmag_r;
  logic                  tneg_r;
  logic [SW-1:0]         spos_r;
  logic [SW-1:0]         sneg_r;
  logic [K_W-1:0]        k_r;
  logic [A_W-1:0]        a_r;
  logic [XM_W-1:0]       b_r;
  logic [A_W-1:0]        acc_r;
  logic [K2_W-1:0]       rem_r;
  logic [DV_W-1:0]       num_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  sisneg_r;
  logic [SW-1:0]         smag_r;
  logic signed [SUM_W-1:0] sum_out_r;
  logic [K_W-1:0]        terms_r;
  logic                  limit_hit_r;

  logic [XM_W-1:0]       raw;
  logic                  xneg_in;
  logic [XM_W-1:0]       xm_in;
  logic [XM_W+UP-1:0]    xs;
  logic [TW-1:0]         tmag_in;
  logic                  tneg_in;
  logic [CMP_W-1:0]      t_cmp;
  logic [CMP_W-1:0]      tol_cmp;
  logic                  met;
  logic [LIMIT_W-1:0]    limit_eff;
  logic [TW-1:0]         p_mul;
  logic [K2_W-1:0]       k_odd;
  logic [K2_W-1:0]       k_even;
  logic [K2_W-1:0]       dvsr;
  logic [K2_W:0]         rt;
  logic                  ge;
  logic [K2_W:0]         rt_sub;
  logic [TW-1:0]         q;
  logic                  tneg_nxt;
  logic                  sisneg_nxt;
  logic [SCW-1:0]        scaled;
  logic [SUM_W-1:0]      mag_out;

  assign raw     = in_x_value;
  assign xneg_in = raw[XM_W-1];
  assign xm_in   = xneg_in ? (~raw + XM_W'(1)) : raw;
  assign xs      = (XM_W+UP)'(xm_in) << UP;
  assign tmag_in = TW'(xs >> DN);
  assign tneg_in = xneg_in && (tmag_in != '0);

  assign t_cmp     = CMP_W'(tmag_r) << TO_CMP;
  assign tol_cmp   = CMP_W'(tolerance) << TOL_SH;
  assign met       = t_cmp < tol_cmp;
  assign limit_eff = (term_limit == '0) ? LIMIT_W'(1) : term_limit;

  assign sts.stop = met || (k_r >= limit_eff);
  assign sts.last = (cnt_r == '0);

  assign p_mul  = acc_r[Q_IN +: TW];
  assign k_odd  = {k_r, 1'b1};
  assign k_even = {k_r, 1'b0} + K2_W'(2);
  assign dvsr   = b_r[K2_W-1:0];

  assign rt     = {rem_r, num_r[DV_W-1]};
  assign ge     = rt >= {1'b0, dvsr};
  assign rt_sub = rt - {1'b0, dvsr};

  assign q        = num_r[TW-1:0];
  assign tneg_nxt = (tneg_r == xneg_r) && (q != '0);

  assign sisneg_nxt = sneg_r > spos_r;

  assign scaled  = (SCW'(smag_r) >> UP) << DN_SH;
  assign mag_out = scaled[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      xneg_r <= xneg_in;
      xm_r   <= xm_in;
      tmag_r <= tmag_in;
      tneg_r <= tneg_in;
      spos_r <= tneg_in ? '0 : SW'(tmag_in);
      sneg_r <= tneg_in ? SW'(tmag_in) : '0;
      k_r    <= K_W'(1);
    end else if (cmd.mul1_start) begin
      a_r   <= A_W'(tmag_r);
      b_r   <= xm_r;
      acc_r <= '0;
      cnt_r <= MUL_LAST;
    end else if (cmd.mul2_start) begin
      a_r   <= A_W'(p_mul);
      b_r   <= XM_W'(k_odd);
      acc_r <= '0;
      cnt_r <= MUL_LAST;
    end else if (cmd.mul_step) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r   <= a_r << 1;
      b_r   <= b_r >> 1;
      cnt_r <= cnt_r - CNT_W'(1);
    end else if (cmd.div_start) begin
      num_r <= acc_r[DV_W-1:0];
      rem_r <= '0;
      b_r   <= XM_W'(k_even);
      cnt_r <= DIV_LAST;
    end else if (cmd.div_step) begin
      rem_r <= ge ? rt_sub[K2_W-1:0] : rt[K2_W-1:0];
      num_r <= {num_r[DV_W-2:0], ge};
      cnt_r <= cnt_r - CNT_W'(1);
    end else if (cmd.acc_term) begin
      tmag_r <= q;
      tneg_r <= tneg_nxt;
      if (tneg_nxt) begin
        sneg_r <= sneg_r + SW'(q);
      end else begin
        spos_r <= spos_r + SW'(q);
      end
      k_r <= k_r + K_W'(1);
    end else if (cmd.fin) begin
      sisneg_r    <= sisneg_nxt;
      smag_r      <= sisneg_nxt ? (sneg_r - spos_r) : (spos_r - sneg_r);
      terms_r     <= k_r;
      limit_hit_r <= !met;
    end else if (cmd.load_out) begin
      sum_out_r <= sisneg_r ? (~mag_out + SUM_W'(1)) : mag_out;
    end
  end

  logic [K_W-1:0] terms_out_r;
  logic           limit_out_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      terms_out_r <= terms_r;
      limit_out_r <= limit_hit_r;
    end
  end

  assign out_series_sum = sum_out_r;
  assign out_terms_used = terms_out_r;
  assign out_limit_hit  = limit_out_r;

endmodule

// File: sv/binomial_series_inv_sqrt_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_series_inv_sqrt_unit
// Sums the binomial series of 1 - 1/sqrt(1+x) for one Q1.30 argument.
//
// Input channel in_*: one argument per transfer. Output channel out_*: one
// result per argument (sum with 30 fraction bits, term count, limit flag).
// Configuration through the APB-style port: tolerance at 0x0, term limit at
// 0x4; write only while the unit is idle.
// One item at a time. After the first term, every further term takes two
// 31-step shift-add multiplies and a (FRACTION_BITS + 17)-step restoring
// divide in the shared datapath, plus control states for the stop test, the
// operand loads and the accumulate. in_stall drops in the cycle after the
// result is loaded.
// The result waits in the output register while out_stall is high; the unit
// then takes and works on the next argument and holds its own result until
// the register frees. Reset empties the output register, returns the
// sequencer to idle and restores the register defaults.
// ----------------------------------------------------------------------------
module binomial_series_inv_sqrt_unit #(
  parameter int FRACTION_BITS = bsis_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bsis_pkg::X_W-1:0]     in_x_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bsis_pkg::SUM_W-1:0]   out_series_sum,
  output logic [bsis_pkg::K_W-1:0]            out_terms_used,
  output logic                                out_limit_hit,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bsis_pkg::PADDR_W-1:0]        paddr,
  input  logic [bsis_pkg::APB_DW-1:0]         pwdata,
  output logic [bsis_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import bsis_pkg::*;

  bsis_cmd_t          cmd;
  bsis_sts_t          sts;
  logic [TOL_W-1:0]   tolerance;
  logic [LIMIT_W-1:0] term_limit;

  bsis_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .tolerance  (tolerance),
    .term_limit (term_limit)
  );

  bsis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsis_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .in_x_value     (in_x_value),
    .tolerance      (tolerance),
    .term_limit     (term_limit),
    .out_series_sum (out_series_sum),
    .out_terms_used (out_terms_used),
    .out_limit_hit  (out_limit_hit)
  );

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> cmd.load_x)
    else $error("input transfer without operand load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled result");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command");

endmodule

// File: tb/binomial_series_inv_sqrt_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_series_inv_sqrt_unit_tb
// Self-checking bench for the binomial series unit. A local bit-exact series
// evaluator predicts sum, term count and limit flag for every accepted
// argument. Directed cases cover the field extremes, the term limit floor, a
// zero tolerance and the x = -1 pattern. Random phases follow, each with new
// register settings. Most add random gaps on both channels; one drains midway.
// ----------------------------------------------------------------------------
module binomial_series_inv_sqrt_unit_tb;
  import bsis_pkg::*;

  localparam int FB      = FRACTION_BITS_DEF;
  localparam int UP      = (FB >= 30) ? FB - 30 : 0;
  localparam int DN      = (FB >= 30) ? 1 : 31 - FB;
  localparam int TO40    = CMP_FRAC - FB;
  localparam int WDOG    = 25000;
  localparam int X_TOP_I = 2**30 - 1;
  localparam logic [TOL_W-1:0]   TOL_CEIL  = 27'd118111600;
  localparam logic [TOL_W-1:0]   TOL_ONES  = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_TOP = 16'd65535;
  localparam logic signed [X_W-1:0] X_TOP   = {1'b0, {(X_W-1){1'b1}}};
  localparam logic signed [X_W-1:0] X_FLOOR = {1'b1, {(X_W-1){1'b0}}};
  localparam logic signed [X_W-1:0] X_ONE_LSB = 31'sd1;
  localparam logic signed [X_W-1:0] X_NEG_LSB = -31'sd1;
  localparam logic signed [63:0] SUM_HI = (64'sd1 <<< (SUM_W-1)) - 1;
  localparam logic signed [63:0] SUM_LO = -(64'sd1 <<< (SUM_W-1));

  typedef struct {
    logic signed [X_W-1:0]   x;
    logic signed [SUM_W-1:0] series_sum;
    logic [K_W-1:0]          terms;
    logic                    limit_hit;
  } series_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [X_W-1:0] in_x_value;
  logic out_valid;
  logic out_stall;
  logic signed [SUM_W-1:0] out_series_sum;
  logic [K_W-1:0] out_terms_used;
  logic out_limit_hit;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  series_result_t pending_sums[$];
  logic [TOL_W-1:0]   tolerance_reg  = TOL_RST;
  logic [LIMIT_W-1:0] term_limit_reg = LIMIT_RST;
  int fail_count = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  binomial_series_inv_sqrt_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_x_value(in_x_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_series_sum(out_series_sum), .out_terms_used(out_terms_used),
    .out_limit_hit(out_limit_hit),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic series_result_t eval_series(input logic signed [X_W-1:0] x);
    series_result_t r;
    logic [X_W-1:0] raw;
    logic [63:0] xm, tmag, spos, sneg, smag, lim, tol40, k;
    logic [127:0] prod;
    logic signed [63:0] s;
    logic xneg, tneg, met, neg_sum;
    raw = x;
    xneg = raw[X_W-1];
    xm = xneg ? (64'h8000_0000 - raw) : 64'(raw);
    lim = (term_limit_reg != 0) ? 64'(term_limit_reg) : 64'd1;
    tol40 = 64'(tolerance_reg) << 10;
    tmag = (xm << UP) >> DN;
    tneg = xneg && tmag != 0;
    spos = tneg ? 64'd0 : tmag;
    sneg = tneg ? tmag : 64'd0;
    k = 64'd1;
    met = (tmag << TO40) < tol40;
    while (!met && k < lim) begin
      prod = (128'(tmag) * xm) >> Q_IN;
      prod = prod * (2 * k + 1) / (2 * k + 2);
      tneg = (tneg == xneg) && prod != 0;
      tmag = prod[63:0];
      if (tneg) sneg += tmag;
      else spos += tmag;
      k++;
      met = (tmag << TO40) < tol40;
    end
    neg_sum = sneg > spos;
    smag = neg_sum ? sneg - spos : spos - sneg;
    if (FB >= 30) smag = smag >> UP;
    else smag = (smag > (64'd1 << (60 - (30 - FB)))) ? (64'd1 << 60) : (smag << (30 - FB));
    if (neg_sum) s = (smag > 64'(SUM_HI) + 1) ? SUM_LO : -$signed(smag);
    else s = (smag > 64'(SUM_HI)) ? SUM_HI : $signed(smag);
    r.x = x;
    r.series_sum = s[SUM_W-1:0];
    r.terms = k[K_W-1:0];
    r.limit_hit = !met;
    return r;
  endfunction

  task automatic flag(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  function automatic int send_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 5);
    return $urandom_range(20, 200);
  endfunction

  function automatic int stall_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 999);
    if (r < 880) return 0;
    if (r < 995) return $urandom_range(1, 6);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic signed [X_W-1:0] rand_x();
    logic signed [X_W-1:0] v;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      v = X_W'($urandom);
    end else if (pick < 9) begin
      v = X_W'($urandom_range(0, X_TOP_I) >> $urandom_range(0, 29));
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      case ($urandom_range(0, 5))
        0: v = '0;
        1: v = X_ONE_LSB;
        2: v = X_NEG_LSB;
        3: v = X_TOP;
        4: v = -X_TOP;
        default: v = X_FLOOR;
      endcase
    end
    return v;
  endfunction

  function automatic logic [PADDR_W-1:0] reg_addr(input logic code);
    logic [PADDR_W-1:0] a;
    a = '0;
    a[REG_SEL_BIT] = code;
    return a;
  endfunction

  task automatic cfg_read_check(input logic code, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] got;
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = reg_addr(code);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
    if (got !== want)
      flag($sformatf("register %0d readback: expected %0d got %0d", code, want, got));
  endtask

  task automatic cfg_write(input logic code, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] kept;
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = reg_addr(code); pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (code == REG_TOLERANCE) begin
      tolerance_reg = value[TOL_W-1:0];
      kept = APB_DW'(tolerance_reg);
    end else begin
      term_limit_reg = value[LIMIT_W-1:0];
      kept = APB_DW'(term_limit_reg);
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    cfg_read_check(code, kept);
  endtask

  // hold the argument until the transfer, then queue its prediction
  task automatic send_x(input logic signed [X_W-1:0] x);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_x_value = x;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_sums.push_back(eval_series(x));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input logic [TOL_W-1:0] tol, input logic [LIMIT_W-1:0] lim);
    drain();
    cfg_write(REG_TOLERANCE, APB_DW'(tol));
    cfg_write(REG_TERM_LIMIT, APB_DW'(lim));
  endtask

  task automatic test_default_registers();
    cfg_read_check(REG_TOLERANCE, APB_DW'(TOL_RST));
    cfg_read_check(REG_TERM_LIMIT, APB_DW'(LIMIT_RST));
    send_x('0);
    send_x(X_ONE_LSB);
    send_x(X_NEG_LSB);
    send_x(31'sd10737418);
    send_x(31'sd268435456);
  endtask

  task automatic test_term_limit_floor();
    configure(TOL_RST, '0);
    send_x(X_TOP);
    send_x(X_FLOOR);
    send_x(-X_TOP);
  endtask

  task automatic test_zero_tolerance();
    configure('0, 16'd5);
    send_x('0);
    send_x(X_TOP);
    send_x(X_FLOOR);
  endtask

  task automatic test_tolerance_extremes();
    configure(27'd1, 16'd12);
    send_x(X_FLOOR);
    send_x(X_TOP);
    send_x(-X_TOP);
    send_x(31'sd1024);
    send_x(-31'sd12345);
    configure(TOL_CEIL, LIMIT_TOP);
    send_x(X_FLOOR);
    send_x(X_TOP);
    send_x(-X_TOP);
    send_x(31'sd536870912);
    configure(TOL_ONES, LIMIT_TOP);
    send_x(X_TOP);
    send_x(-X_TOP);
  endtask

  task automatic test_random_settings();
    logic [TOL_W-1:0] tol;
    logic [LIMIT_W-1:0] lim;
    for (int round = 0; round < 10; round++) begin
      case (round)
        0: begin tol = TOL_RST;  lim = 16'd8;    end
        1: begin tol = TOL_CEIL; lim = LIMIT_TOP; end
        2: begin tol = 27'd1;    lim = 16'd16;   end
        default: begin
          tol = TOL_W'($urandom_range(0, 2**TOL_W - 1) >> $urandom_range(0, 26));
          lim = LIMIT_W'($urandom_range(0, 24));
        end
      endcase
      configure(tol, lim);
      repeat (50) send_x(rand_x());
    end
  endtask

  task automatic test_back_to_back();
    configure(TOL_RST, 16'd6);
    no_idle = 1'b1;
    repeat (50) send_x(rand_x());
    drain();
    no_idle = 1'b0;
  endtask

  // pause the sender mid-stream until every result is back
  task automatic test_pipeline_pressure();
    configure(TOL_W'($urandom_range(1, 2**20)), 16'd12);
    repeat (20) send_x(rand_x());
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (20) send_x(rand_x());
  endtask

  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0 && !no_idle) begin
        out_stall = 1'b1;
        hold--;
      end else begin
        out_stall = 1'b0;
        hold = stall_len();
      end
    end
  end

  always @(posedge clk) begin
    series_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_sums.size() == 0) begin
        flag($sformatf("unexpected result: sum %0d terms %0d limit %0b",
                       out_series_sum, out_terms_used, out_limit_hit));
      end else begin
        want = pending_sums.pop_front();
        if (out_series_sum !== want.series_sum || out_terms_used !== want.terms ||
            out_limit_hit !== want.limit_hit)
          flag($sformatf("x %0d: sum exp %0d got %0d, terms exp %0d got %0d, limit exp %0b got %0b",
                         want.x, want.series_sum, out_series_sum, want.terms, out_terms_used,
                         want.limit_hit, out_limit_hit));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_default_registers();
    test_term_limit_floor();
    test_zero_tolerance();
    test_tolerance_extremes();
    test_random_settings();
    test_back_to_back();
    test_pipeline_pressure();
    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
